// ===== rtl/mvbt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the mesh volume / box tightness core.
// No dependencies; every other file refers to it by scoped names.
package mvbt_pkg;

	// Default coordinate width (signed Q8.4 at 12 bits).
	localparam int COORD_BITS_DEF = 12;

	// Fixed result widths.
	localparam int SUM_W     = 60;
	localparam int SIX_W     = 58;
	localparam int BOX_OUT_W = 36;
	localparam int Q_W       = 16;
	localparam int CNT_W     = $clog2(Q_W);

	// Accumulator clamp limits.
	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	// Controller to datapath commands.
	typedef struct packed {
		logic cap;    // capture the accepted triangle
		logic minor;  // form the three 2x2 minors
		logic term;   // form the three cofactor terms
		logic acc;    // accumulate the determinant, update the box
		logic box1;   // magnitude of the sum, x*y extent product
		logic box2;   // box volume
		logic den;    // six times the box volume
		logic chk;    // saturation check, divider setup
		logic div;    // one quotient bit
		logic load;   // load the result register
	} dp_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic final_tri;  // captured triangle is the last of the mesh
		logic sat;        // ratio saturates (zero box or ratio of one or more)
	} dp_status_t;

endpackage

// ===== rtl/mvbt_in_if.sv =====
`timescale 1ns / 1ps
// Triangle channel: valid/ready handshake with nine corner coordinates.
// Depends on mvbt_pkg for the default coordinate width.
interface mvbt_in_if #(
	parameter int COORD_BITS = mvbt_pkg::COORD_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] ax;
	logic signed [COORD_BITS-1:0] ay;
	logic signed [COORD_BITS-1:0] az;
	logic signed [COORD_BITS-1:0] bx;
	logic signed [COORD_BITS-1:0] by;
	logic signed [COORD_BITS-1:0] bz;
	logic signed [COORD_BITS-1:0] cx;
	logic signed [COORD_BITS-1:0] cy;
	logic signed [COORD_BITS-1:0] cz;
	logic                         final_triangle;

	modport source (output valid, ax, ay, az, bx, by, bz, cx, cy, cz, final_triangle,
		input ready);
	modport sink (input valid, ax, ay, az, bx, by, bz, cx, cy, cz, final_triangle,
		output ready);
endinterface

// ===== rtl/mvbt_out_if.sv =====
`timescale 1ns / 1ps
// Result channel: valid/ready handshake with volume, box and tightness fields.
// Depends on mvbt_pkg for widths.
interface mvbt_out_if #(
	parameter int COORD_BITS = mvbt_pkg::COORD_BITS_DEF
);
	logic                               valid;
	logic                               ready;
	logic [mvbt_pkg::SIX_W-1:0]         six_volume;
	logic [mvbt_pkg::BOX_OUT_W-1:0]     bound_vol;
	logic [mvbt_pkg::Q_W-1:0]           tightness;
	logic signed [COORD_BITS-1:0]       min_x;
	logic signed [COORD_BITS-1:0]       min_y;
	logic signed [COORD_BITS-1:0]       min_z;
	logic signed [COORD_BITS-1:0]       max_x;
	logic signed [COORD_BITS-1:0]       max_y;
	logic signed [COORD_BITS-1:0]       max_z;

	modport source (output valid, six_volume, bound_vol, tightness,
		min_x, min_y, min_z, max_x, max_y, max_z, input ready);
	modport sink (input valid, six_volume, bound_vol, tightness,
		min_x, min_y, min_z, max_x, max_y, max_z, output ready);
endinterface

// ===== rtl/mvbt_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: determinant, saturating accumulator, bounding box, box volume,
// bit-serial tightness quotient and result register. Depends on mvbt_pkg.
module mvbt_datapath #(
	parameter int COORD_BITS = mvbt_pkg::COORD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  mvbt_pkg::dp_cmd_t                 cmd,
	output mvbt_pkg::dp_status_t              status,
	input  logic signed [COORD_BITS-1:0]      coord [9],
	input  logic                              final_triangle,
	output logic [mvbt_pkg::SIX_W-1:0]        six_volume,
	output logic [mvbt_pkg::BOX_OUT_W-1:0]    bound_vol,
	output logic [mvbt_pkg::Q_W-1:0]          tightness,
	output logic signed [COORD_BITS-1:0]      lo_corner [3],
	output logic signed [COORD_BITS-1:0]      hi_corner [3]
);
	localparam int CB     = COORD_BITS;
	localparam int PROD_W = 2 * CB;
	localparam int MIN_W  = 2 * CB + 1;
	localparam int TERM_W = 3 * CB + 1;
	localparam int DET_W  = 3 * CB + 3;
	localparam int BOX_W  = 3 * CB;
	localparam int DEN_W  = 3 * CB + 3;
	localparam int REM_W  = DEN_W + 1;
	localparam int SW     = mvbt_pkg::SUM_W;
	localparam int XW     = mvbt_pkg::SIX_W;
	localparam int QW     = mvbt_pkg::Q_W;

	localparam logic signed [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
	localparam logic signed [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};

	// captured triangle
	logic signed [CB-1:0]     p_q [9];
	logic                     fin_q;
	// pipeline of the determinant
	logic signed [MIN_W-1:0]  minor_q [3];
	logic signed [TERM_W-1:0] term_q [3];
	// running state
	logic signed [SW-1:0]     acc_q;
	logic signed [CB-1:0]     lo_q [3];
	logic signed [CB-1:0]     hi_q [3];
	// snapshot of the finished mesh
	logic signed [SW-1:0]     sum_f_q;
	logic signed [CB-1:0]     lo_f_q [3];
	logic signed [CB-1:0]     hi_f_q [3];
	// finishing arithmetic
	logic [XW-1:0]            six_q;
	logic [PROD_W-1:0]        dxy_q;
	logic [CB-1:0]            dz_q;
	logic [BOX_W-1:0]         box_q;
	logic [DEN_W-1:0]         den_q;
	logic [REM_W-1:0]         rem_q;
	logic [QW-1:0]            q_q;
	// result register
	logic [XW-1:0]            six_o_q;
	logic [BOX_W-1:0]         box_o_q;
	logic [QW-1:0]            q_o_q;
	logic signed [CB-1:0]     lo_o_q [3];
	logic signed [CB-1:0]     hi_o_q [3];

	// combinational
	logic signed [PROD_W-1:0] prod [6];
	logic signed [MIN_W-1:0]  minor_n [3];
	logic signed [TERM_W-1:0] term_n [3];
	logic signed [DET_W-1:0]  det;
	logic signed [SW:0]       sum_wide;
	logic signed [SW-1:0]     acc_n;
	logic signed [CB-1:0]     lo_n [3];
	logic signed [CB-1:0]     hi_n [3];
	logic [SW-1:0]            mag;
	logic [XW-1:0]            six_n;
	logic signed [CB:0]       ext [3];
	logic [REM_W-1:0]         rem_sh;
	logic [REM_W-1:0]         den_ext;

	// 2x2 minors of the corner matrix
	always_comb begin
		prod[0] = p_q[4] * p_q[8];
		prod[1] = p_q[7] * p_q[5];
		prod[2] = p_q[1] * p_q[8];
		prod[3] = p_q[7] * p_q[2];
		prod[4] = p_q[1] * p_q[5];
		prod[5] = p_q[4] * p_q[2];
		minor_n[0] = MIN_W'(prod[0]) - MIN_W'(prod[1]);
		minor_n[1] = MIN_W'(prod[2]) - MIN_W'(prod[3]);
		minor_n[2] = MIN_W'(prod[4]) - MIN_W'(prod[5]);
	end

	// cofactor expansion along the x column
	always_comb begin
		term_n[0] = p_q[0] * minor_q[0];
		term_n[1] = p_q[3] * minor_q[1];
		term_n[2] = p_q[6] * minor_q[2];
		det = DET_W'(term_q[0]) - DET_W'(term_q[1]) + DET_W'(term_q[2]);
	end

	// saturating accumulate
	always_comb begin
		sum_wide = (SW+1)'(acc_q) + (SW+1)'(det);
		if (sum_wide[SW] != sum_wide[SW-1]) begin
			acc_n = sum_wide[SW] ? mvbt_pkg::SUM_MIN : mvbt_pkg::SUM_MAX;
		end else begin
			acc_n = sum_wide[SW-1:0];
		end
	end

	// box update over the three corners
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			lo_n[i] = lo_q[i];
			hi_n[i] = hi_q[i];
			for (int k = 0; k < 3; k++) begin
				if (p_q[k*3+i] < lo_n[i]) lo_n[i] = p_q[k*3+i];
				if (p_q[k*3+i] > hi_n[i]) hi_n[i] = p_q[k*3+i];
			end
		end
	end

	// magnitude of the sum, clamped
	always_comb begin
		mag = sum_f_q[SW-1] ? SW'(-sum_f_q) : SW'(sum_f_q);
		if (mag[SW-1:XW] != '0) begin
			six_n = '1;
		end else begin
			six_n = mag[XW-1:0];
		end
		for (int i = 0; i < 3; i++) begin
			ext[i] = (CB+1)'(hi_f_q[i]) - (CB+1)'(lo_f_q[i]);
		end
	end

	// restoring divider step
	always_comb begin
		rem_sh  = {rem_q[REM_W-2:0], 1'b0};
		den_ext = REM_W'(den_q);
	end

	assign status.final_tri = fin_q;
	assign status.sat = (box_q == '0) || (six_q >= XW'(den_q));

	// running state: cleared after every final triangle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_q <= 1'b0;
			acc_q <= '0;
			for (int i = 0; i < 3; i++) begin
				lo_q[i] <= CMAX;
				hi_q[i] <= CMIN;
			end
		end else begin
			if (cmd.cap) fin_q <= final_triangle;
			if (cmd.acc) begin
				if (fin_q) begin
					acc_q <= '0;
					for (int i = 0; i < 3; i++) begin
						lo_q[i] <= CMAX;
						hi_q[i] <= CMIN;
					end
				end else begin
					acc_q <= acc_n;
					lo_q  <= lo_n;
					hi_q  <= hi_n;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.cap) p_q <= coord;
		if (cmd.minor) minor_q <= minor_n;
		if (cmd.term) term_q <= term_n;
		if (cmd.acc && fin_q) begin
			sum_f_q <= acc_n;
			lo_f_q  <= lo_n;
			hi_f_q  <= hi_n;
		end
		if (cmd.box1) begin
			six_q <= six_n;
			dxy_q <= ext[0][CB-1:0] * ext[1][CB-1:0];
			dz_q  <= ext[2][CB-1:0];
		end
		if (cmd.box2) box_q <= dxy_q * dz_q;
		if (cmd.den) den_q <= (DEN_W'(box_q) << 2) + (DEN_W'(box_q) << 1);
		if (cmd.chk) begin
			q_q   <= status.sat ? '1 : '0;
			rem_q <= REM_W'(six_q);
		end
		if (cmd.div) begin
			if (rem_sh >= den_ext) begin
				rem_q <= rem_sh - den_ext;
				q_q   <= {q_q[QW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				q_q   <= {q_q[QW-2:0], 1'b0};
			end
		end
		if (cmd.load) begin
			six_o_q <= six_q;
			box_o_q <= box_q;
			q_o_q   <= q_q;
			lo_o_q  <= lo_f_q;
			hi_o_q  <= hi_f_q;
		end
	end

	assign six_volume = six_o_q;
	assign bound_vol  = mvbt_pkg::BOX_OUT_W'(box_o_q);
	assign tightness  = q_o_q;
	assign lo_corner  = lo_o_q;
	assign hi_corner  = hi_o_q;

endmodule

// ===== rtl/mvbt_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sequences one triangle through the datapath and, on the last
// triangle, the box volume, quotient loop and result register. Depends on mvbt_pkg.
module mvbt_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  mvbt_pkg::dp_status_t  status,
	output mvbt_pkg::dp_cmd_t     cmd
);
	localparam int CW = mvbt_pkg::CNT_W;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_MINOR = 4'd1;
	localparam logic [3:0] ST_TERM  = 4'd2;
	localparam logic [3:0] ST_ACC   = 4'd3;
	localparam logic [3:0] ST_BOX1  = 4'd4;
	localparam logic [3:0] ST_BOX2  = 4'd5;
	localparam logic [3:0] ST_DEN   = 4'd6;
	localparam logic [3:0] ST_CHK   = 4'd7;
	localparam logic [3:0] ST_DIV   = 4'd8;
	localparam logic [3:0] ST_OUT   = 4'd9;

	localparam logic [CW-1:0] LAST_BIT = CW'(mvbt_pkg::Q_W - 1);

	logic [3:0]    state_q, state_n;
	logic [CW-1:0] cnt_q;
	logic          out_valid_q;
	logic          out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd      = '0;
		state_n  = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.cap = 1'b1;
					state_n = ST_MINOR;
				end
			end
			ST_MINOR: begin
				cmd.minor = 1'b1;
				state_n   = ST_TERM;
			end
			ST_TERM: begin
				cmd.term = 1'b1;
				state_n  = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				state_n = status.final_tri ? ST_BOX1 : ST_IDLE;
			end
			ST_BOX1: begin
				cmd.box1 = 1'b1;
				state_n  = ST_BOX2;
			end
			ST_BOX2: begin
				cmd.box2 = 1'b1;
				state_n  = ST_DEN;
			end
			ST_DEN: begin
				cmd.den = 1'b1;
				state_n = ST_CHK;
			end
			ST_CHK: begin
				cmd.chk = 1'b1;
				state_n = status.sat ? ST_OUT : ST_DIV;
			end
			ST_DIV: begin
				cmd.div = 1'b1;
				if (cnt_q == LAST_BIT) state_n = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					cmd.load = 1'b1;
					state_n  = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.chk) begin
				cnt_q <= '0;
			end else if (cmd.div) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/mesh_volume_box_tightness_core.sv =====
`timescale 1ns / 1ps
// Top level of the mesh volume / bounding box tightness core.
// Depends on mvbt_pkg, mvbt_in_if, mvbt_out_if, mvbt_ctrl and mvbt_datapath.
//
//   channel    dir   item                                  handshake
//   triangle   in    nine corner coordinates + last flag   valid/ready
//   result     out   volume, box volume, tightness, box    valid/ready
//
// Sequence: a triangle passes through accept, minors, terms and accumulate;
// ready is high only in accept, so no new triangle is taken before the last
// is accumulated. The last triangle of a mesh then goes through magnitude
// and x*y extent, box volume, six times the box, saturation check, the 16-bit
// quotient loop (one bit per cycle, skipped on saturation) and the hand-off.
// Reset: arst_n clears the controller, the accumulator and the bounding box.
// Stalls: a finished result sits in the result register while new triangles
// stream in; only the next mesh's result waits for it to be taken.
module mesh_volume_box_tightness_core #(
	parameter int COORD_BITS = mvbt_pkg::COORD_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	mvbt_in_if.sink    triangle,
	mvbt_out_if.source result
);
	mvbt_pkg::dp_cmd_t            cmd;
	mvbt_pkg::dp_status_t         status;
	logic signed [COORD_BITS-1:0] coord [9];
	logic signed [COORD_BITS-1:0] lo_corner [3];
	logic signed [COORD_BITS-1:0] hi_corner [3];

	// Gather the corners row by row: a, b, c, each as x, y, z.
	assign coord = '{triangle.ax, triangle.ay, triangle.az,
		triangle.bx, triangle.by, triangle.bz,
		triangle.cx, triangle.cy, triangle.cz};

	// Sequence the work: accept, determinant steps, and on the last triangle
	// the box volume, quotient loop and result hand-off.
	mvbt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (triangle.valid),
		.in_ready  (triangle.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Hold the arithmetic, the running state and the result register.
	mvbt_datapath #(
		.COORD_BITS (COORD_BITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.coord          (coord),
		.final_triangle (triangle.final_triangle),
		.six_volume     (result.six_volume),
		.bound_vol      (result.bound_vol),
		.tightness      (result.tightness),
		.lo_corner      (lo_corner),
		.hi_corner      (hi_corner)
	);

	// Spread the box corners onto the result fields.
	assign result.min_x = lo_corner[0];
	assign result.min_y = lo_corner[1];
	assign result.min_z = lo_corner[2];
	assign result.max_x = hi_corner[0];
	assign result.max_y = hi_corner[1];
	assign result.max_z = hi_corner[2];

endmodule
